FILE: hdl/srt_pkg.sv
// srt_pkg: sizes, codes, record types and field checks for the sorted record table.
// No dependencies; imported by srt_engine, sorted_record_table and srt_checker.
package srt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OUT_W    = 7;
	localparam int KEY_W    = 40;
	localparam int HANDLE_W = 32;

	localparam logic [5:0]  DAY_MAX   = 6'd32;
	localparam logic [3:0]  MONTH_MAX = 4'd13;
	localparam logic [11:0] YEAR_MIN  = 12'd1900;
	localparam logic [11:0] YEAR_MAX  = 12'd2010;
	localparam logic [7:0]  BLD_A     = 8'h41;
	localparam logic [7:0]  BLD_B     = 8'h42;
	localparam logic [7:0]  BLD_C     = 8'h43;

	typedef enum logic [1:0] {
		FN_LOOKUP = 2'd0,
		FN_INSERT = 2'd1,
		FN_DELETE = 2'd2,
		FN_UPDATE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NOT_FOUND    = 3'd1,
		ST_DUPLICATE    = 3'd2,
		ST_FULL         = 3'd3,
		ST_BAD_DATE     = 3'd4,
		ST_BAD_BUILDING = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]  building;
		logic [3:0]  grant;
		logic [11:0] year;
		logic [3:0]  month;
		logic [5:0]  day;
	} detail_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		detail_t             detail;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		func_t               func;
		logic [KEY_W-1:0]    key;
		detail_t             detail;
		logic [HANDLE_W-1:0] handle;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [OUT_W-1:0]    position;
		logic [OUT_W-1:0]    entry_count;
		detail_t             detail;
		logic [HANDLE_W-1:0] handle;
	} res_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
	} ram_req_t;

	function automatic logic date_ok(detail_t d);
		return (d.day <= DAY_MAX) && (d.month <= MONTH_MAX) &&
			(d.year >= YEAR_MIN) && (d.year <= YEAR_MAX);
	endfunction

	function automatic logic building_ok(detail_t d);
		return (d.building == BLD_A) || (d.building == BLD_B) || (d.building == BLD_C);
	endfunction

endpackage

FILE: hdl/srt_if.sv
// srt_req_if / srt_rsp_if: valid-ready channels carrying one item each.
// No dependencies.
interface srt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [39:0] key;
	logic [5:0]  birth_day;
	logic [3:0]  birth_month;
	logic [11:0] birth_year;
	logic [3:0]  grant_level;
	logic [7:0]  building;
	logic [31:0] name_handle;

	modport source (output valid, func, key, birth_day, birth_month, birth_year,
		grant_level, building, name_handle, input ready);
	modport sink (input valid, func, key, birth_day, birth_month, birth_year,
		grant_level, building, name_handle, output ready);
	modport monitor (input valid, ready, func, key, birth_day, birth_month,
		birth_year, grant_level, building, name_handle);
endinterface

interface srt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [6:0]  position;
	logic [6:0]  entry_count;
	logic [5:0]  out_day;
	logic [3:0]  out_month;
	logic [11:0] out_year;
	logic [3:0]  out_grant;
	logic [7:0]  out_building;
	logic [31:0] out_handle;

	modport source (output valid, status, position, entry_count, out_day, out_month,
		out_year, out_grant, out_building, out_handle, input ready);
	modport sink (input valid, status, position, entry_count, out_day, out_month,
		out_year, out_grant, out_building, out_handle, output ready);
	modport monitor (input valid, ready, status, position, entry_count, out_day,
		out_month, out_year, out_grant, out_building, out_handle);
endinterface

FILE: hdl/srt_ram.sv
// srt_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/srt_engine.sv
// srt_engine: binary search and shift sequencer over the record RAM.
// Depends on srt_pkg and srt_req_if; drives the RAM through a ram_req_t.
module srt_engine import srt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	srt_req_if.sink  req,
	output logic     res_valid,
	input  logic     res_ready,
	output res_t     res,
	output ram_req_t ram_req,
	input  entry_t   ram_rdata
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_PROBE  = 8'b0000_0010,
		S_CMP    = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_SHIFT  = 8'b0001_0000,
		S_TAIL   = 8'b0010_0000,
		S_WRITE  = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             pend_s1;
	logic [IDX_W-1:0] waddr_s1;

	cmd_t             cmd_q;
	logic [CNT_W-1:0] lo_q, hi_q, pos_q;
	logic [IDX_W-1:0] mid_q, j_q, end_q;
	logic             hit_q, ins_q, wr_after_q;
	entry_t           fnd_q;
	res_t             res_q;

	logic [CNT_W-1:0] mid_sum;
	logic             range_ok, key_hit, key_lt, last_j;
	logic             d_ok, b_ok;
	status_t          dec_status;
	logic             dec_show_fnd, dec_show_new, dec_shift, dec_write, dec_ins;
	logic [CNT_W-1:0] dec_count;
	entry_t           new_entry;

	assign mid_sum   = lo_q + ((hi_q - lo_q) >> 1);
	assign range_ok  = lo_q < hi_q;
	assign key_hit   = ram_rdata.key == cmd_q.key;
	assign key_lt    = cmd_q.key < ram_rdata.key;
	assign last_j    = j_q == end_q;
	assign d_ok      = date_ok(cmd_q.detail);
	assign b_ok      = building_ok(cmd_q.detail);
	assign new_entry = '{key: cmd_q.key, detail: cmd_q.detail, handle: cmd_q.handle};

	assign req.ready = state_q == S_IDLE;
	assign res_valid = state_q == S_RESULT;
	assign res       = res_q;

	// RAM port: probe reads, shift reads, delayed shift writes, final store
	always_comb begin
		ram_req.re    = ((state_q == S_PROBE) && range_ok) || (state_q == S_SHIFT);
		ram_req.raddr = (state_q == S_SHIFT) ? j_q : mid_sum[IDX_W-1:0];
		ram_req.we    = pend_s1 || (state_q == S_WRITE);
		ram_req.waddr = pend_s1 ? waddr_s1 : pos_q[IDX_W-1:0];
		ram_req.wdata = pend_s1 ? ram_rdata : new_entry;
	end

	// decision after the search
	always_comb begin
		dec_status   = ST_OK;
		dec_show_fnd = 1'b0;
		dec_show_new = 1'b0;
		dec_shift    = 1'b0;
		dec_write    = 1'b0;
		dec_ins      = 1'b0;
		dec_count    = count_q;
		unique case (cmd_q.func)
			FN_LOOKUP: begin
				if (hit_q) dec_show_fnd = 1'b1;
				else dec_status = ST_NOT_FOUND;
			end
			FN_INSERT: begin
				priority if (hit_q) begin
					dec_status   = ST_DUPLICATE;
					dec_show_fnd = 1'b1;
				end else if (!d_ok) begin
					dec_status = ST_BAD_DATE;
				end else if (!b_ok) begin
					dec_status = ST_BAD_BUILDING;
				end else if (count_q >= CNT_W'(CAPACITY)) begin
					dec_status = ST_FULL;
				end else begin
					dec_show_new = 1'b1;
					dec_ins      = 1'b1;
					dec_write    = 1'b1;
					dec_shift    = count_q > pos_q;
					dec_count    = count_q + CNT_W'(1);
				end
			end
			FN_DELETE: begin
				if (!hit_q) begin
					dec_status = ST_NOT_FOUND;
				end else begin
					dec_show_fnd = 1'b1;
					dec_shift    = (pos_q + CNT_W'(1)) < count_q;
					dec_count    = count_q - CNT_W'(1);
				end
			end
			FN_UPDATE: begin
				priority if (!hit_q) begin
					dec_status = ST_NOT_FOUND;
				end else if (!d_ok) begin
					dec_status   = ST_BAD_DATE;
					dec_show_fnd = 1'b1;
				end else if (!b_ok) begin
					dec_status   = ST_BAD_BUILDING;
					dec_show_fnd = 1'b1;
				end else begin
					dec_show_new = 1'b1;
					dec_write    = 1'b1;
				end
			end
			default: dec_status = ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= state_q == S_SHIFT;
			unique case (state_q)
				S_IDLE:   if (req.valid) state_q <= S_PROBE;
				S_PROBE:  state_q <= range_ok ? S_CMP : S_DECIDE;
				S_CMP:    state_q <= key_hit ? S_DECIDE : S_PROBE;
				S_DECIDE: begin
					count_q <= dec_count;
					if (dec_shift) state_q <= S_SHIFT;
					else if (dec_write) state_q <= S_WRITE;
					else state_q <= S_RESULT;
				end
				S_SHIFT:  if (last_j) state_q <= S_TAIL;
				S_TAIL:   state_q <= wr_after_q ? S_WRITE : S_RESULT;
				S_WRITE:  state_q <= S_RESULT;
				S_RESULT: if (res_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cmd_q.func   <= func_t'(req.func);
					cmd_q.key    <= req.key;
					cmd_q.detail <= '{building: req.building, grant: req.grant_level,
						year: req.birth_year, month: req.birth_month, day: req.birth_day};
					cmd_q.handle <= req.name_handle;
					lo_q         <= '0;
					hi_q         <= count_q;
				end
			end
			S_PROBE: begin
				mid_q <= mid_sum[IDX_W-1:0];
				if (!range_ok) begin
					hit_q <= 1'b0;
					pos_q <= lo_q;
				end
			end
			S_CMP: begin
				priority if (key_hit) begin
					hit_q <= 1'b1;
					pos_q <= CNT_W'(mid_q);
					fnd_q <= ram_rdata;
				end else if (key_lt) begin
					hi_q <= CNT_W'(mid_q);
				end else begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end
			end
			S_DECIDE: begin
				ins_q      <= dec_ins;
				wr_after_q <= dec_write;
				if (dec_ins) begin
					j_q   <= IDX_W'(count_q - CNT_W'(1));
					end_q <= pos_q[IDX_W-1:0];
				end else begin
					j_q   <= IDX_W'(pos_q + CNT_W'(1));
					end_q <= IDX_W'(count_q - CNT_W'(1));
				end
				res_q.status      <= dec_status;
				res_q.position    <= OUT_W'(pos_q);
				res_q.entry_count <= OUT_W'(dec_count);
				priority if (dec_show_new) begin
					res_q.detail <= cmd_q.detail;
					res_q.handle <= cmd_q.handle;
				end else if (dec_show_fnd) begin
					res_q.detail <= fnd_q.detail;
					res_q.handle <= fnd_q.handle;
				end else begin
					res_q.detail <= '0;
					res_q.handle <= '0;
				end
			end
			S_SHIFT: begin
				if (ins_q) begin
					j_q      <= j_q - IDX_W'(1);
					waddr_s1 <= j_q + IDX_W'(1);
				end else begin
					j_q      <= j_q + IDX_W'(1);
					waddr_s1 <= j_q - IDX_W'(1);
				end
			end
			S_TAIL, S_WRITE, S_RESULT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/sorted_record_table.sv
// sorted_record_table: top level, sorted record table with binary search.
// Depends on srt_pkg, srt_if, srt_ram and srt_engine.
//
//  channel  dir  modport           payload
//  -------  ---  ----------------  ---------------------------------------------
//  req      in   srt_req_if.sink   func, key, birth date, grant, building, handle
//  rsp      out  srt_rsp_if.source status, position, entry_count, stored fields
//
// One item at a time. Each item is accepted, searched with at most log2(CAPACITY)+1
// probes, plus one closing probe on a miss, decided and then answered. A shifting
// insert moves entries up one place at a time and a shifting delete moves them down,
// then an insert or an update stores its entry. The slowest items at CAPACITY 64 are
// an insert at index 0 of 63 entries and a delete of index 0 of 64, since the record
// RAM has a single port per direction.
// Reset clears the state machine and the entry count; RAM contents need no clear.
// The result sits in an output register, so a stalled rsp only holds the next
// item once it is finished.
module sorted_record_table import srt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	srt_req_if.sink   req,
	srt_rsp_if.source rsp
);

	ram_req_t ram_req;
	entry_t   ram_rdata;
	logic     res_valid, res_ready;
	res_t     res;

	// output register
	logic     vld_q;
	res_t     out_q;

	// one wide word per record: key, packed details, handle
	srt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_srt_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	srt_engine u_srt_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// engine may hand over a result whenever the register is empty or draining
	assign res_ready = !vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_ready) begin
			vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = vld_q;
	assign rsp.status       = out_q.status;
	assign rsp.position     = out_q.position;
	assign rsp.entry_count  = out_q.entry_count;
	assign rsp.out_day      = out_q.detail.day;
	assign rsp.out_month    = out_q.detail.month;
	assign rsp.out_year     = out_q.detail.year;
	assign rsp.out_grant    = out_q.detail.grant;
	assign rsp.out_building = out_q.detail.building;
	assign rsp.out_handle   = out_q.handle;

endmodule

FILE: hdl/srt_checker.sv
// srt_checker: port-level assertions for sorted_record_table, bound to the top.
// Depends on srt_pkg and srt_if.
module srt_checker import srt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	srt_req_if.sink   req,
	srt_rsp_if.source rsp
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status <= ST_BAD_BUILDING))
		else $error("status code out of range");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.position <= rsp.entry_count))
		else $error("position beyond entry count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("new item taken while search in progress");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_NOT_FOUND) |->
			(rsp.out_handle == '0 && rsp.out_building == '0 && rsp.out_year == '0))
		else $error("fields not cleared for absent key");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.status) &&
			$stable(rsp.position) && $stable(rsp.out_handle)))
		else $error("stalled result changed");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
